>>> rtl/itxseg_pkg.sv
// Shared types and constants for the ISO-TP transmit segmenter.
package itxseg_pkg;

  // Longest message that is still segmented; longer ones give an error word
  localparam logic [15:0] MAX_MESSAGE_BYTES = 16'd4095;

  // Byte counter saturation value
  localparam logic [15:0] COUNT_SAT = 16'hFFFF;

  // Highest standard (11-bit) identifier
  localparam logic [28:0] STD_ID_MAX = 29'h7FF;

  // Protocol control nibbles
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  // Frame geometry
  localparam logic [2:0]  FRAME_BYTES       = 3'd7;
  localparam logic [2:0]  FIRST_FRAME_BYTES = 3'd6;
  localparam logic [15:0] SINGLE_MAX_LEN    = 16'd7;
  localparam logic [15:0] FIRST_DATA_LEN    = 16'd6;
  localparam logic [3:0]  DLC_EMPTY         = 4'd1;
  localparam logic [3:0]  DLC_FULL          = 4'd8;
  localparam logic [3:0]  DLC_ERROR         = 4'd0;
  localparam logic [3:0]  SEQ_START         = 4'd1;

  // Per-message mode
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SINGLE,
    MODE_MULTI,
    MODE_DISCARD
  } mode_t;

  // Input word: one message byte with its message context
  typedef struct packed {
    logic [28:0] can_id;
    logic [15:0] message_length;
    logic [7:0]  data_byte;
    logic        has_byte;
  } in_word_t;

  // Result word: one CAN frame or an error marker
  typedef struct packed {
    logic [28:0] frame_id;
    logic        ext_frame;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_payload;
    logic        last_frame;
    logic        length_error;
  } out_word_t;

  // Held input word with its valid flag
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

endpackage

>>> rtl/itxseg_in_stage.sv
// Input register of the segmenter: holds one accepted word until processed.
module itxseg_in_stage import itxseg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     take,
  output stage_t   held
);

  logic     valid_r;
  in_word_t word_r;

  // Stall only while a held word cannot move on
  assign in_stall   = valid_r && !take;
  assign held.valid = valid_r;
  assign held.word  = word_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || take) begin
      valid_r <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if ((!valid_r || take) && in_valid) begin
      word_r <= in_data;
    end
  end

endmodule

>>> rtl/itxseg_core.sv
// Segmentation state machine: per-word frame assembly and PCI generation.
module itxseg_core import itxseg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  stage_t    held,
  input  logic      room,
  output logic      take,
  output logic      res_valid,
  output out_word_t res
);

  logic [15:0] bytes_seen_r, bytes_seen_nxt;
  logic [55:0] frame_buf_r, frame_buf_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [3:0]  seq_r, seq_nxt;
  mode_t       mode_r, mode_nxt;

  logic        go;
  logic        done;
  logic [15:0] prev_seen;
  logic [15:0] len;

  assign len = held.word.message_length;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      frame_buf_r  <= '0;
      fill_r       <= '0;
      seq_r        <= SEQ_START;
      mode_r       <= MODE_IDLE;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      frame_buf_r  <= frame_buf_nxt;
      fill_r       <= fill_nxt;
      seq_r        <= seq_nxt;
      mode_r       <= mode_nxt;
    end
  end

  // Next state and result for the held word
  always_comb begin
    take           = held.valid && room;
    bytes_seen_nxt = bytes_seen_r;
    frame_buf_nxt  = frame_buf_r;
    fill_nxt       = fill_r;
    seq_nxt        = seq_r;
    mode_nxt       = mode_r;
    go             = 1'b0;
    done           = 1'b0;
    prev_seen      = bytes_seen_r;

    res_valid         = 1'b0;
    res.frame_id      = held.word.can_id;
    res.ext_frame     = (held.word.can_id > STD_ID_MAX);
    res.frame_dlc     = DLC_ERROR;
    res.frame_payload = '0;
    res.last_frame    = 1'b0;
    res.length_error  = 1'b0;

    // Message start, empty message and over-length check
    if (take) begin
      if (mode_r == MODE_IDLE) begin
        if (len == 16'd0) begin
          res_valid      = 1'b1;
          res.frame_dlc  = DLC_EMPTY;
          res.last_frame = 1'b1;
        end else if (held.word.has_byte) begin
          bytes_seen_nxt = '0;
          frame_buf_nxt  = '0;
          fill_nxt       = '0;
          seq_nxt        = SEQ_START;
          if (len > MAX_MESSAGE_BYTES) begin
            res_valid        = 1'b1;
            res.last_frame   = 1'b1;
            res.length_error = 1'b1;
            bytes_seen_nxt   = 16'd1;
            mode_nxt         = (16'd1 >= len) ? MODE_IDLE : MODE_DISCARD;
          end else begin
            mode_nxt = (len <= SINGLE_MAX_LEN) ? MODE_SINGLE : MODE_MULTI;
            go       = 1'b1;
          end
        end
      end else begin
        go = held.word.has_byte;
      end
    end

    // Byte handling
    if (go) begin
      prev_seen = bytes_seen_nxt;
      if (bytes_seen_nxt != COUNT_SAT) begin
        bytes_seen_nxt = bytes_seen_nxt + 16'd1;
      end
      done = (bytes_seen_nxt >= len);

      if (mode_nxt == MODE_DISCARD) begin
        if (done) begin
          mode_nxt       = MODE_IDLE;
          bytes_seen_nxt = '0;
        end
      end else begin
        // place the byte in the next free lane
        if (fill_nxt != FRAME_BYTES) begin
          for (int k = 0; k < 7; k++) begin
            if (fill_nxt == 3'(k)) begin
              frame_buf_nxt[55-8*k -: 8] = frame_buf_nxt[55-8*k -: 8] | held.word.data_byte;
            end
          end
          fill_nxt = fill_nxt + 3'd1;
        end

        if (mode_nxt == MODE_SINGLE) begin
          // single frame
          if (done || fill_nxt == FRAME_BYTES) begin
            res_valid         = 1'b1;
            res.frame_dlc     = {1'b0, fill_nxt} + 4'd1;
            res.frame_payload = {5'd0, fill_nxt, frame_buf_nxt};
            res.last_frame    = 1'b1;
            frame_buf_nxt     = '0;
            fill_nxt          = '0;
            bytes_seen_nxt    = '0;
            mode_nxt          = MODE_IDLE;
          end
        end else if (prev_seen < FIRST_DATA_LEN) begin
          // first frame: 12-bit length and six bytes
          if (fill_nxt >= FIRST_FRAME_BYTES || done) begin
            res_valid         = 1'b1;
            res.frame_dlc     = DLC_FULL;
            res.frame_payload = {PCI_FIRST, len[11:8], len[7:0], frame_buf_nxt[55:8]};
            res.last_frame    = done;
            frame_buf_nxt     = '0;
            fill_nxt          = '0;
            seq_nxt           = SEQ_START;
            if (done) begin
              bytes_seen_nxt = '0;
              mode_nxt       = MODE_IDLE;
            end
          end
        end else if (fill_nxt == FRAME_BYTES || done) begin
          // consecutive frame, sequence number wraps through zero
          res_valid         = 1'b1;
          res.frame_dlc     = {1'b0, fill_nxt} + 4'd1;
          res.frame_payload = {PCI_CONSEC, seq_nxt, frame_buf_nxt};
          res.last_frame    = done;
          frame_buf_nxt     = '0;
          fill_nxt          = '0;
          seq_nxt           = seq_nxt + 4'd1;
          if (done) begin
            bytes_seen_nxt = '0;
            seq_nxt        = SEQ_START;
            mode_nxt       = MODE_IDLE;
          end
        end
      end
    end
  end

endmodule

>>> rtl/itxseg_out_stage.sv
// Result register of the segmenter: holds a frame word until it is taken.
module itxseg_out_stage import itxseg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_word_t res,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      valid_r;
  out_word_t word_r;

  // Free when empty or being drained this cycle
  assign room      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = word_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= res_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (room && res_valid) begin
      word_r <= res;
    end
  end

endmodule

>>> rtl/isotp_tx_segmenter.sv
// ISO-TP transmit segmenter: cuts message bytes into single, first and consecutive frames.
// A frame word is written to the output register in the cycle after its input word is taken.
// Throughput: 1 input word per cycle while the result register has room; the segmentation state updates once per word.
// A word that closes no frame produces nothing; at most one frame word per input word.
// Reset (rst_n low, synchronous): both registers empty, mode idle, counters cleared,
// sequence number back to 1.
module isotp_tx_segmenter import itxseg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  stage_t    held;
  logic      take;
  logic      room;
  logic      res_valid;
  out_word_t res;

  // Input register
  itxseg_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .held     (held)
  );

  // Segmentation state and frame build
  itxseg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .held      (held),
    .room      (room),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  itxseg_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Input only backs up when the result register is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result word");

  // Error word carries no frame and closes the message
  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.length_error) |->
      (out_data.last_frame && out_data.frame_dlc == DLC_ERROR && out_data.frame_payload == '0))
    else $error("malformed length error word");

  // Real frames have a dlc of 1 to 8
  a_frame_dlc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.length_error) |->
      (out_data.frame_dlc >= DLC_EMPTY && out_data.frame_dlc <= DLC_FULL))
    else $error("frame dlc out of range");

  // Extended flag follows the identifier
  a_ext_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ext_frame == (out_data.frame_id > STD_ID_MAX)))
    else $error("extended identifier flag mismatch");

endmodule
